### rtl/i2cmrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmrr_pkg
// Shared widths, phase codes and payload types of the I2C register read unit.
// ----------------------------------------------------------------------------
package i2cmrr_pkg;

  localparam int DEV_W = 7;
  localparam int BYTE_W = 8;
  localparam int TPU_W = 16;
  localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(1);

  // Input item op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Completion status codes
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NACK = 1'b1;

  // Bus sequencer phases
  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_IDLE = 4'd0;
  localparam logic [PH_W-1:0] PH_START = 4'd1;
  localparam logic [PH_W-1:0] PH_ADDR_W = 4'd2;
  localparam logic [PH_W-1:0] PH_REG = 4'd3;
  localparam logic [PH_W-1:0] PH_RESTART = 4'd4;
  localparam logic [PH_W-1:0] PH_ADDR_R = 4'd5;
  localparam logic [PH_W-1:0] PH_RX = 4'd6;
  localparam logic [PH_W-1:0] PH_STOP_OK = 4'd7;
  localparam logic [PH_W-1:0] PH_STOP_FAIL = 4'd8;

  typedef struct packed {
    logic              op;
    logic [DEV_W-1:0]  dev_addr;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] byte_count;
    logic              sda_in;
  } in_item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_pull_low;
    logic [BYTE_W-1:0] rx_data;
    logic              rx_valid;
    logic              busy_res;
    logic              done_res;
    logic              status;
  } out_item_t;

endpackage

### rtl/i2cmrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmrr_in_if / i2cmrr_out_if
// Valid/ready channels carrying command/tick items in and bus results out.
// ----------------------------------------------------------------------------
interface i2cmrr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [i2cmrr_pkg::DEV_W-1:0]   dev_addr;
  logic [i2cmrr_pkg::BYTE_W-1:0]  reg_addr;
  logic [i2cmrr_pkg::BYTE_W-1:0]  byte_count;
  logic                           sda_in;

  modport source (output valid, op, dev_addr, reg_addr, byte_count, sda_in, input ready);
  modport sink (input valid, op, dev_addr, reg_addr, byte_count, sda_in, output ready);
endinterface

interface i2cmrr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           scl_out;
  logic                           sda_pull_low;
  logic [i2cmrr_pkg::BYTE_W-1:0]  rx_data;
  logic                           rx_valid;
  logic                           busy_res;
  logic                           done_res;
  logic                           status;

  modport source (output valid, scl_out, sda_pull_low, rx_data, rx_valid, busy_res,
                  done_res, status, input ready);
  modport sink (input valid, scl_out, sda_pull_low, rx_data, rx_valid, busy_res,
                done_res, status, output ready);
endinterface

### rtl/i2c_master_register_read_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_read_unit
// I2C master register read: start, address+write, register byte, repeated
// start, address+read, N data bytes, stop. One result per input item.
// ----------------------------------------------------------------------------
// Each input item (a start command or one time tick) produces exactly one
// result carrying the SCL/SDA drive levels, any received byte and the
// busy/done/status flags. The unit takes one item per clock as long as the
// result side keeps up: an item is registered on entry, the sequencer works
// it once the result slot is open, and the result sits in an output register.
// ticks_per_unit sets how many tick items make one quarter of a bus bit.
module i2c_master_register_read_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [i2cmrr_pkg::TPU_W-1:0]  cfg_wdata,
  i2cmrr_in_if.sink                     in_ch,
  i2cmrr_out_if.source                  out_ch
);
  import i2cmrr_pkg::*;

  logic [TPU_W-1:0] ticks_per_unit;
  in_item_t         in_item;
  logic             in_valid_q;
  in_item_t         in_q;
  logic             out_open;
  logic             work;
  out_item_t        seq_res;
  logic             out_valid_q;
  out_item_t        out_q;

  i2cmrr_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .ticks_per_unit (ticks_per_unit)
  );

  assign in_item = '{op: in_ch.op, dev_addr: in_ch.dev_addr, reg_addr: in_ch.reg_addr,
                     byte_count: in_ch.byte_count, sda_in: in_ch.sda_in};

  // Pipeline flow: output slot free or draining
  assign out_open = !out_valid_q || out_ch.ready;
  assign work = in_valid_q && out_open;
  assign in_ch.ready = !in_valid_q || out_open;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_item;
    end
  end

  i2cmrr_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .step           (work),
    .item           (in_q),
    .ticks_per_unit (ticks_per_unit),
    .res            (seq_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (out_open) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_q <= seq_res;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.scl_out = out_q.scl_out;
  assign out_ch.sda_pull_low = out_q.sda_pull_low;
  assign out_ch.rx_data = out_q.rx_data;
  assign out_ch.rx_valid = out_q.rx_valid;
  assign out_ch.busy_res = out_q.busy_res;
  assign out_ch.done_res = out_q.done_res;
  assign out_ch.status = out_q.status;

  // Completion ends the transaction
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done result still reports busy");

  // A byte arrives only inside a transaction
  a_rx_in_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.rx_valid |-> out_ch.busy_res && !out_ch.done_res)
    else $error("received byte outside a transaction");

  // Failure status only comes with completion
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status |-> out_ch.done_res)
    else $error("status set without done");

  // Full pipe with a stalled result must back-pressure the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted with both stages full");

endmodule

### rtl/i2cmrr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmrr_seq
// Bus sequencer: holds the transaction state and, for each item it is fed,
// computes the pin levels, received byte and completion flags.
// ----------------------------------------------------------------------------
module i2cmrr_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  i2cmrr_pkg::in_item_t          item,
  input  logic [i2cmrr_pkg::TPU_W-1:0]  ticks_per_unit,
  output i2cmrr_pkg::out_item_t         res
);
  import i2cmrr_pkg::*;

  logic [PH_W-1:0]   phase, phase_next;
  logic [3:0]        bit_counter, bit_counter_next;
  logic [BYTE_W-1:0] shift_reg, shift_reg_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [TPU_W-1:0]  tick_divider, tick_divider_next;
  logic [DEV_W-1:0]  held_device, held_device_next;
  logic [BYTE_W-1:0] held_register, held_register_next;
  logic [1:0]        quarter_step, quarter_step_next;

  logic [TPU_W-1:0]  tpu_eff;
  logic [TPU_W:0]    div_inc;
  logic [BYTE_W-1:0] rx_shift;
  logic [BYTE_W-1:0] bytes_dec;
  logic              pin_scl, pin_sda;

  // Pin levels for a given bus step
  function automatic logic [1:0] drive_pins(input logic [PH_W-1:0] ph, input logic [1:0] q,
                                            input logic [3:0] bc, input logic [BYTE_W-1:0] sr,
                                            input logic [BYTE_W-1:0] bl);
    logic hi;
    logic scl, sda;
    hi = (q == 2'd1) || (q == 2'd2);
    scl = 1'b1;
    sda = 1'b0;
    case (ph)
      PH_START: begin
        scl = (q == 2'd0);
        sda = 1'b1;
      end
      PH_ADDR_W, PH_REG, PH_ADDR_R: begin
        scl = hi;
        sda = bc[3] ? 1'b0 : ~sr[BYTE_W-1];
      end
      PH_RESTART: begin
        scl = hi;
        sda = q[1];
      end
      PH_RX: begin
        scl = hi;
        sda = bc[3] ? (bl > BYTE_W'(1)) : 1'b0;
      end
      PH_STOP_OK, PH_STOP_FAIL: begin
        scl = (q != 2'd0);
        sda = (q <= 2'd1);
      end
      default: begin
        scl = 1'b1;
        sda = 1'b0;
      end
    endcase
    return {scl, sda};
  endfunction

  assign tpu_eff = (ticks_per_unit == '0) ? TPU_W'(1) : ticks_per_unit;
  assign div_inc = {1'b0, tick_divider} + (TPU_W+1)'(1);
  assign rx_shift = {shift_reg[BYTE_W-2:0], item.sda_in};
  assign bytes_dec = bytes_left - BYTE_W'(1);

  // Next state and result for one item
  always_comb begin
    phase_next = phase;
    bit_counter_next = bit_counter;
    shift_reg_next = shift_reg;
    bytes_left_next = bytes_left;
    tick_divider_next = tick_divider;
    held_device_next = held_device;
    held_register_next = held_register;
    quarter_step_next = quarter_step;
    res = '0;

    if (item.op == OP_START) begin
      if (phase == PH_IDLE) begin
        held_device_next = item.dev_addr;
        held_register_next = item.reg_addr;
        bytes_left_next = item.byte_count;
        tick_divider_next = '0;
        phase_next = PH_START;
        shift_reg_next = '0;
        bit_counter_next = '0;
        quarter_step_next = '0;
      end
    end else if (phase != PH_IDLE) begin
      if (div_inc >= {1'b0, tpu_eff}) begin
        tick_divider_next = '0;
        quarter_step_next = quarter_step + 2'd1;
        case (phase)
          PH_START: begin
            if (quarter_step != 2'd0) begin
              phase_next = PH_ADDR_W;
              shift_reg_next = {held_device, 1'b0};
              bit_counter_next = '0;
              quarter_step_next = '0;
            end
          end
          PH_ADDR_W, PH_REG, PH_ADDR_R: begin
            if (bit_counter[3]) begin
              if (quarter_step == 2'd1) shift_reg_next = {{(BYTE_W-1){1'b0}}, item.sda_in};
              if (quarter_step == 2'd3) begin
                bit_counter_next = '0;
                quarter_step_next = '0;
                shift_reg_next = '0;
                if (shift_reg[0]) begin
                  phase_next = PH_STOP_FAIL;
                end else if (phase == PH_ADDR_W) begin
                  phase_next = PH_REG;
                  shift_reg_next = held_register;
                end else if (phase == PH_REG) begin
                  phase_next = PH_RESTART;
                end else if (bytes_left == '0) begin
                  phase_next = PH_STOP_OK;
                end else begin
                  phase_next = PH_RX;
                end
              end
            end else if (quarter_step == 2'd3) begin
              shift_reg_next = {shift_reg[BYTE_W-2:0], 1'b0};
              bit_counter_next = bit_counter + 4'd1;
              quarter_step_next = '0;
            end
          end
          PH_RESTART: begin
            if (quarter_step == 2'd3) begin
              phase_next = PH_ADDR_R;
              shift_reg_next = {held_device, 1'b1};
              bit_counter_next = '0;
              quarter_step_next = '0;
            end
          end
          PH_RX: begin
            if (!bit_counter[3]) begin
              if (quarter_step == 2'd1) begin
                shift_reg_next = rx_shift;
                if (bit_counter == 4'd7) begin
                  res.rx_data = rx_shift;
                  res.rx_valid = 1'b1;
                end
              end
              if (quarter_step == 2'd3) begin
                bit_counter_next = bit_counter + 4'd1;
                quarter_step_next = '0;
              end
            end else if (quarter_step == 2'd3) begin
              bytes_left_next = bytes_dec;
              phase_next = (bytes_dec == '0) ? PH_STOP_OK : PH_RX;
              shift_reg_next = '0;
              bit_counter_next = '0;
              quarter_step_next = '0;
            end
          end
          PH_STOP_OK, PH_STOP_FAIL: begin
            if (quarter_step[1]) begin
              res.done_res = 1'b1;
              res.status = (phase == PH_STOP_FAIL) ? STATUS_NACK : STATUS_OK;
              phase_next = PH_IDLE;
              shift_reg_next = '0;
              bit_counter_next = '0;
              quarter_step_next = '0;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            shift_reg_next = '0;
            bit_counter_next = '0;
            quarter_step_next = '0;
          end
        endcase
      end else begin
        tick_divider_next = div_inc[TPU_W-1:0];
      end
    end

    // Ticks show the step in force on arrival; a start shows the new state
    if (item.op == OP_START) begin
      {pin_scl, pin_sda} = drive_pins(phase_next, quarter_step_next, bit_counter_next,
                                      shift_reg_next, bytes_left_next);
    end else begin
      {pin_scl, pin_sda} = drive_pins(phase, quarter_step, bit_counter, shift_reg,
                                      bytes_left);
    end
    res.scl_out = pin_scl;
    res.sda_pull_low = pin_sda;
    res.busy_res = (phase_next != PH_IDLE);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_counter <= '0;
      shift_reg <= '0;
      bytes_left <= '0;
      tick_divider <= '0;
      held_device <= '0;
      held_register <= '0;
      quarter_step <= '0;
    end else if (step) begin
      phase <= phase_next;
      bit_counter <= bit_counter_next;
      shift_reg <= shift_reg_next;
      bytes_left <= bytes_left_next;
      tick_divider <= tick_divider_next;
      held_device <= held_device_next;
      held_register <= held_register_next;
      quarter_step <= quarter_step_next;
    end
  end

endmodule

### rtl/i2cmrr_seq_wrap_unused.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmrr_cfg
// Timing register, ticks per step; user's job: written when idle, unchecked.
// ----------------------------------------------------------------------------
module i2cmrr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [i2cmrr_pkg::TPU_W-1:0]  cfg_wdata,
  output logic [i2cmrr_pkg::TPU_W-1:0]  ticks_per_unit
);
  import i2cmrr_pkg::*;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TPU_RESET;
    end else if (cfg_we) begin
      ticks_per_unit <= cfg_wdata;
    end
  end

endmodule
